@@ src/serial_frame_receiver_checksum_macros.svh @@
// Assertion helpers for the serial frame receiver.
// Each macro samples on clk; the first two are quiet while rst is high.
`ifndef SERIAL_FRAME_RECEIVER_CHECKSUM_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CHECKSUM_MACROS_SVH

// Same-cycle implication, off during reset.
`define SFRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SFRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SFRC_ASSERT_NXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sfrc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sfrc_pkg;

  localparam int FRAME_LEN_DEF   = 10;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Register indexes on the config port.
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_ACK   = 2'd1;
  localparam logic [1:0] REG_NAK   = 2'd2;

  localparam logic [7:0] START_CODE_RST = 8'h02;
  localparam logic [7:0] ACK_CODE_RST   = 8'h06;
  localparam logic [7:0] NAK_CODE_RST   = 8'h15;

  // Result kinds.
  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_NAK = 2'd1;
  localparam logic [1:0] KIND_OK  = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  // Byte classes set by the front end.
  localparam logic [1:0] CLS_ACK   = 2'd0;
  localparam logic [1:0] CLS_NAK   = 2'd1;
  localparam logic [1:0] CLS_START = 2'd2;
  localparam logic [1:0] CLS_DATA  = 2'd3;

  localparam int PAYLOAD_W = 48;
  localparam int SUM_W     = 8;

  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] data;
  } token_t;

  // Returns {valid, value} for an ASCII hex digit, either case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/serial_frame_receiver_checksum.sv @@
// A result is registered in the output register once the token queue has passed on the byte
//   which completes it and the output register is free.
// Throughput: one byte per cycle while m_tready is high, set by the one-token-per-cycle frame engine.
// The two-entry token queue absorbs a stalled master side for two bytes.
// Reset (rst, synchronous, active high): back to idle, queue empty, codes to 2/6/21.
`timescale 1ns / 1ps
`default_nettype none
module serial_frame_receiver_checksum #(
  parameter int FRAME_LEN   = sfrc_pkg::FRAME_LEN_DEF,
  parameter int QUEUE_DEPTH = sfrc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration writes: index 0 start code, 1 ack code, 2 nak code.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // Received bytes.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Results.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [47:0] payload, [55:48] sum_seen
  output logic [1:0]       m_tuser    // [1:0] kind
);
  import sfrc_pkg::*;

  token_t               front_tok;
  token_t               queue_tok;
  logic                 queue_full;
  logic                 queue_empty;
  logic                 queue_pop;
  logic                 push;
  logic [PAYLOAD_W-1:0] payload;
  logic [SUM_W-1:0]     sum_seen;

  // Take a byte whenever the queue has room; the back end drains it on its own.
  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  // Front: hold the code registers and classify each byte.
  sfrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (s_tdata),
    .tok       (front_tok)
  );

  // Queue the classified bytes so the input side waits on a stalled result only once the queue is full.
  sfrc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (front_tok),
    .pop      (queue_pop),
    .pop_tok  (queue_tok),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  // Back: run the frame state, checksum compare and the output register.
  sfrc_back #(
    .FRAME_LEN (FRAME_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .tok_valid   (!queue_empty),
    .tok         (queue_tok),
    .tok_pop     (queue_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (m_tuser),
    .out_payload (payload),
    .out_sum     (sum_seen)
  );

  assign m_tdata = {sum_seen, payload};

endmodule
`default_nettype wire

@@ src/sfrc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sfrc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [7:0]      cfg_data,
  input  wire logic [7:0]      rx_byte,
  output sfrc_pkg::token_t     tok
);
  import sfrc_pkg::*;

  logic [7:0] start_code;
  logic [7:0] ack_code;
  logic [7:0] nak_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= START_CODE_RST;
      ack_code   <= ACK_CODE_RST;
      nak_code   <= NAK_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START: start_code <= cfg_data;
        REG_ACK:   ack_code   <= cfg_data;
        REG_NAK:   nak_code   <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Ack wins over nak, nak over start.
  always_comb begin
    tok.data = rx_byte;
    if (rx_byte == ack_code) begin
      tok.cls = CLS_ACK;
    end else if (rx_byte == nak_code) begin
      tok.cls = CLS_NAK;
    end else if (rx_byte == start_code) begin
      tok.cls = CLS_START;
    end else begin
      tok.cls = CLS_DATA;
    end
  end

endmodule
`default_nettype wire

@@ src/sfrc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sfrc_fifo #(
  parameter int DEPTH = sfrc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sfrc_pkg::token_t push_tok,
  input  wire logic             pop,
  output sfrc_pkg::token_t      pop_tok,
  output logic                  full,
  output logic                  empty
);
  import sfrc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  token_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_tok = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/sfrc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sfrc_back #(
  parameter int FRAME_LEN = sfrc_pkg::FRAME_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tok_valid,
  input  wire sfrc_pkg::token_t              tok,
  output logic                               tok_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_kind,
  output logic [sfrc_pkg::PAYLOAD_W-1:0]     out_payload,
  output logic [sfrc_pkg::SUM_W-1:0]         out_sum
);
  import sfrc_pkg::*;

  localparam logic [3:0] IDX_PAY_LAST = 4'(FRAME_LEN - 4);
  localparam logic [3:0] IDX_ETX      = 4'(FRAME_LEN - 3);
  localparam logic [3:0] IDX_HIGH     = 4'(FRAME_LEN - 2);

  logic                 in_frame,      in_frame_next;
  logic [3:0]           byte_index,    byte_index_next;
  logic [SUM_W-1:0]     running_sum,   running_sum_next;
  logic [PAYLOAD_W-1:0] payload_shift, payload_shift_next;
  logic [3:0]           high_digit,    high_digit_next;
  logic                 digit_bad,     digit_bad_next;

  logic                 emit;
  logic [1:0]           emit_kind;
  logic [PAYLOAD_W-1:0] emit_payload;
  logic [SUM_W-1:0]     emit_sum;
  logic [4:0]           hex;

  assign tok_pop = tok_valid && (!out_valid || out_ready);
  assign hex     = hex_decode(tok.data);

  always_comb begin
    in_frame_next      = in_frame;
    byte_index_next    = byte_index;
    running_sum_next   = running_sum;
    payload_shift_next = payload_shift;
    high_digit_next    = high_digit;
    digit_bad_next     = digit_bad;
    emit               = 1'b0;
    emit_kind          = KIND_ERR;
    emit_payload       = '0;
    emit_sum           = '0;

    case (tok.cls)
      CLS_ACK, CLS_NAK: begin
        in_frame_next      = 1'b0;
        byte_index_next    = '0;
        running_sum_next   = '0;
        payload_shift_next = '0;
        high_digit_next    = '0;
        digit_bad_next     = 1'b0;
        emit               = 1'b1;
        emit_kind          = (tok.cls == CLS_ACK) ? KIND_ACK : KIND_NAK;
      end
      CLS_START: begin
        // Abort an open frame; open a new one only from idle.
        running_sum_next   = '0;
        payload_shift_next = '0;
        high_digit_next    = '0;
        digit_bad_next     = 1'b0;
        if (in_frame) begin
          in_frame_next   = 1'b0;
          byte_index_next = '0;
          emit            = 1'b1;
          emit_sum        = running_sum;
        end else begin
          in_frame_next   = 1'b1;
          byte_index_next = 4'd1;
        end
      end
      default: begin
        if (in_frame) begin
          byte_index_next = byte_index + 4'd1;
          if (byte_index <= IDX_PAY_LAST) begin
            payload_shift_next = {payload_shift[PAYLOAD_W-9:0], tok.data};
            running_sum_next   = running_sum + tok.data;
          end else if (byte_index == IDX_ETX) begin
            running_sum_next   = running_sum + tok.data;
          end else if (byte_index == IDX_HIGH) begin
            high_digit_next    = hex[3:0];
            digit_bad_next     = !hex[4];
          end else begin
            emit     = 1'b1;
            emit_sum = running_sum;
            if (hex[4] && !digit_bad && ({high_digit, hex[3:0]} == running_sum)) begin
              emit_kind    = KIND_OK;
              emit_payload = payload_shift;
            end
            in_frame_next      = 1'b0;
            byte_index_next    = '0;
            running_sum_next   = '0;
            payload_shift_next = '0;
            high_digit_next    = '0;
            digit_bad_next     = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_index    <= '0;
      running_sum   <= '0;
      payload_shift <= '0;
      high_digit    <= '0;
      digit_bad     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (tok_pop) begin
        in_frame      <= in_frame_next;
        byte_index    <= byte_index_next;
        running_sum   <= running_sum_next;
        payload_shift <= payload_shift_next;
        high_digit    <= high_digit_next;
        digit_bad     <= digit_bad_next;
      end
      if (tok_pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      out_kind    <= emit_kind;
      out_payload <= emit_payload;
      out_sum     <= emit_sum;
    end
  end

endmodule
`default_nettype wire

@@ src/sfrc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "serial_frame_receiver_checksum_macros.svh"
module sfrc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import sfrc_pkg::*;

  `SFRC_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `SFRC_ASSERT_IMP(a_payload_zero, m_tvalid && (m_tuser != KIND_OK), m_tdata[47:0] == 48'd0, "payload set on a non-ok result")
  `SFRC_ASSERT_IMP(a_ack_sum_zero, m_tvalid && ((m_tuser == KIND_ACK) || (m_tuser == KIND_NAK)), m_tdata[55:48] == 8'd0, "sum set on ack or nak")
  `SFRC_ASSERT_NXT_ALWAYS(a_reset_idle, rst, !m_tvalid, "result offered after reset")

endmodule

bind serial_frame_receiver_checksum sfrc_checker u_sfrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
